// ===== rtl/wst_pkg.sv =====
package wst_pkg;

    localparam int WHEELS = 4;
    localparam int IDX_W  = $clog2(WHEELS);
    localparam int CNT_W  = 3;

    localparam logic [CNT_W-1:0] WHEEL_LIMIT = CNT_W'(WHEELS);

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_HALT     = 2'd1;
    localparam logic [1:0] ACT_SHUTDOWN = 2'd2;

    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_TIMEOUT   = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_MODE      = 4'h8;

    localparam logic [14:0] THRESHOLD_RST = 15'd32767;
    localparam logic [31:0] TIMEOUT_RST   = 32'd1000;

    typedef struct packed {
        logic over;
        logic expired;
    } t_lane_res;

    typedef struct packed {
        logic [1:0]        stop_action;
        logic [IDX_W-1:0]  stop_wheel;
        logic [WHEELS-1:0] over_mask;
        logic              stop_latched;
    } t_result;

endpackage

// ===== rtl/wst_lane.sv =====
module wst_lane (
    input  logic               i_clk,
    input  logic               i_accept,
    input  logic               i_covered,
    input  logic               i_newly,
    input  logic [31:0]        i_timestamp,
    input  logic signed [15:0] i_velocity,
    input  logic [14:0]        i_threshold,
    input  logic [31:0]        i_timeout,
    output wst_pkg::t_lane_res o_res
);

    logic [31:0] r_last_ok;
    logic [16:0] mag;
    logic [31:0] elapsed;
    logic        over;

    // The most negative velocity gives a magnitude of 32768, hence 17 bits.
    assign mag     = i_velocity[15] ? (17'd0 - {1'b1, i_velocity}) : {1'b0, i_velocity};
    assign over    = i_covered && (mag >= {2'b00, i_threshold});
    // A newly covered wheel counts as stamped with this message's time.
    assign elapsed = i_newly ? 32'd0 : (i_timestamp - r_last_ok);

    assign o_res.over    = over;
    assign o_res.expired = over && (elapsed >= i_timeout);

    always_ff @(posedge i_clk) begin
        if (i_accept && i_covered && (i_newly || !over)) begin
            r_last_ok <= i_timestamp;
        end
    end

endmodule

// ===== rtl/wst_merge.sv =====
module wst_merge (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_shutdown_mode,
    input  wst_pkg::t_lane_res i_lanes [wst_pkg::WHEELS],
    output wst_pkg::t_result   o_result
);

    logic                        r_latch;
    logic                        n_latch;
    logic                        any_expired;
    logic                        fire;
    logic [wst_pkg::IDX_W-1:0]   first_idx;
    logic [wst_pkg::WHEELS-1:0]  mask;

    always_comb begin
        any_expired = 1'b0;
        first_idx   = '0;
        mask        = '0;
        for (int i = wst_pkg::WHEELS - 1; i >= 0; i--) begin
            mask[i] = i_lanes[i].over;
            if (i_lanes[i].expired) begin
                any_expired = 1'b1;
                first_idx   = wst_pkg::IDX_W'(i);
            end
        end
    end

    assign fire = any_expired && !r_latch;

    // A message with every covered wheel under threshold releases the latch.
    assign n_latch = (mask == '0) ? 1'b0 : (r_latch || any_expired);

    assign o_result.stop_action  = !fire ? wst_pkg::ACT_NONE :
                                   (i_shutdown_mode ? wst_pkg::ACT_SHUTDOWN : wst_pkg::ACT_HALT);
    assign o_result.stop_wheel   = fire ? first_idx : '0;
    assign o_result.over_mask    = mask;
    assign o_result.stop_latched = n_latch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= 1'b0;
        end else if (i_accept) begin
            r_latch <= n_latch;
        end
    end

endmodule

// ===== rtl/wst_out_buf.sv =====
module wst_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wst_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_stall,
    output wst_pkg::t_result o_data
);

    logic             r_main_valid;
    logic             r_skid_valid;
    wst_pkg::t_result r_main;
    wst_pkg::t_result r_skid;
    logic             take;

    assign take    = r_main_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (take) begin
            r_main_valid <= i_push;
        end else if (i_push) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_main <= r_skid;
            end
        end else if (i_push) begin
            if (take || !r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

// ===== rtl/wheel_spin_timeout_monitor.sv =====
// An accepted message's result is registered in the output buffer behind any waiting result.
// Throughput: one message per cycle while o_in_stall is low, with the four wheel lanes checked
// side by side and a two-entry output buffer that keeps taking messages while a result waits.
// Reset (synchronous, active low) clears the stop latch, the known wheel count,
// the output buffer and the configuration registers; wheel time stamps are not reset.
module wheel_spin_timeout_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wst_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [31:0]                   i_timestamp,
    input  logic [wst_pkg::CNT_W-1:0]     i_wheel_count,
    input  logic signed [15:0]            i_velocity_0,
    input  logic signed [15:0]            i_velocity_1,
    input  logic signed [15:0]            i_velocity_2,
    input  logic signed [15:0]            i_velocity_3,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_stop_action,
    output logic [wst_pkg::IDX_W-1:0]     o_stop_wheel,
    output logic [wst_pkg::WHEELS-1:0]    o_over_mask,
    output logic                          o_stop_latched
);

    logic [14:0]               r_threshold;
    logic [31:0]               r_timeout;
    logic                      r_mode;
    logic [wst_pkg::CNT_W-1:0] r_known;
    logic [wst_pkg::CNT_W-1:0] count;
    logic                      accept;
    logic                      cfg_write;
    logic signed [15:0]        velocity [wst_pkg::WHEELS];
    wst_pkg::t_lane_res        lanes [wst_pkg::WHEELS];
    wst_pkg::t_result          result;
    wst_pkg::t_result          out_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign accept    = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (paddr)
            wst_pkg::ADDR_THRESHOLD: prdata = {17'd0, r_threshold};
            wst_pkg::ADDR_TIMEOUT:   prdata = r_timeout;
            wst_pkg::ADDR_MODE:      prdata = {31'd0, r_mode};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= wst_pkg::THRESHOLD_RST;
            r_timeout   <= wst_pkg::TIMEOUT_RST;
            r_mode      <= 1'b0;
        end else if (cfg_write) begin
            unique case (paddr)
                wst_pkg::ADDR_THRESHOLD: r_threshold <= pwdata[14:0];
                wst_pkg::ADDR_TIMEOUT:   r_timeout   <= pwdata;
                wst_pkg::ADDR_MODE:      r_mode      <= pwdata[0];
                default:                 ;
            endcase
        end
    end

    // Counts beyond the number of wheels saturate.
    assign count = (i_wheel_count > wst_pkg::WHEEL_LIMIT) ? wst_pkg::WHEEL_LIMIT : i_wheel_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_known <= '0;
        end else if (accept) begin
            r_known <= count;
        end
    end

    assign velocity[0] = i_velocity_0;
    assign velocity[1] = i_velocity_1;
    assign velocity[2] = i_velocity_2;
    assign velocity[3] = i_velocity_3;

    for (genvar g = 0; g < wst_pkg::WHEELS; g++) begin : g_lane
        logic covered;
        logic newly;

        assign covered = wst_pkg::CNT_W'(g) < count;
        assign newly   = covered && (wst_pkg::CNT_W'(g) >= r_known);

        wst_lane u_lane (
            .i_clk       (i_clk),
            .i_accept    (accept),
            .i_covered   (covered),
            .i_newly     (newly),
            .i_timestamp (i_timestamp),
            .i_velocity  (velocity[g]),
            .i_threshold (r_threshold),
            .i_timeout   (r_timeout),
            .o_res       (lanes[g])
        );
    end

    wst_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_shutdown_mode (r_mode),
        .i_lanes         (lanes),
        .o_result        (result)
    );

    wst_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (result),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_data)
    );

    assign o_stop_action  = out_data.stop_action;
    assign o_stop_wheel   = out_data.stop_wheel;
    assign o_over_mask    = out_data.over_mask;
    assign o_stop_latched = out_data.stop_latched;

endmodule

// ===== rtl/wst_checker.sv =====
module wst_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [1:0]                 o_stop_action,
    input logic [wst_pkg::IDX_W-1:0]  o_stop_wheel,
    input logic [wst_pkg::WHEELS-1:0] o_over_mask,
    input logic                       o_stop_latched
);

    // The input side only backs up once a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_stop_action)
            && $stable(o_stop_wheel) && $stable(o_over_mask) && $stable(o_stop_latched)))
        else $error("stalled result changed");

    a_fire_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_stop_action != wst_pkg::ACT_NONE))
            |-> (o_stop_latched && (o_over_mask != '0)))
        else $error("stop fired without latch or over wheel");

    a_wheel_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_stop_action == wst_pkg::ACT_NONE)) |-> (o_stop_wheel == '0))
        else $error("stop wheel reported without a stop");

    a_fired_wheel_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_stop_action != wst_pkg::ACT_NONE)) |-> o_over_mask[o_stop_wheel])
        else $error("fired wheel is not over threshold");

endmodule

bind wheel_spin_timeout_monitor wst_checker u_wst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_stop_action  (o_stop_action),
    .o_stop_wheel   (o_stop_wheel),
    .o_over_mask    (o_over_mask),
    .o_stop_latched (o_stop_latched)
);
